// ===== sv/mlsr_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mlsr_pkg: shared types and constants of the level slew ramp
// Field widths, reset values, queue entry type and the angle mapping.
// ----------------------------------------------------------------------------
package mlsr_pkg;

	localparam int LEVEL_W     = 6;
	localparam int MS_W        = 10;
	localparam int RATE_W      = 8;
	localparam int ANGLE_W     = 9;
	localparam int IN_DATA_W   = 16;
	localparam int OUT_DATA_W  = 16;
	localparam int MAX_LEVEL   = 20;
	localparam int QUEUE_DEPTH = 4;
	localparam int QPTR_W      = 2;

	localparam logic [RATE_W-1:0] RATE_RESET = RATE_W'(60);

	localparam logic FUNC_SET  = 1'b0;
	localparam logic FUNC_TICK = 1'b1;

	typedef struct packed {
		logic               func;
		logic [LEVEL_W-1:0] level;
		logic [MS_W-1:0]    ms;
	} entry_t;

	// half-degree servo angle of a drive level: 9*level + 180
	function automatic logic [ANGLE_W-1:0] angle_of(input logic [LEVEL_W-1:0] lv);
		logic signed [ANGLE_W:0] a;
		a = (ANGLE_W+1)'(signed'(lv)) * 10'sd9 + 10'sd180;
		return a[ANGLE_W-1:0];
	endfunction

endpackage

// ===== sv/mlsr_front.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mlsr_front: input side of the level slew ramp
// Accepts beats, saturates the requested level and queues the items.
// ----------------------------------------------------------------------------
module mlsr_front
	import mlsr_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 s_axis_tvalid,
	output logic                 s_axis_tready,
	input  logic [IN_DATA_W-1:0] s_axis_tdata,
	input  logic                 s_axis_tuser,
	input  logic                 pop,
	output logic                 head_valid,
	output entry_t               head
);

	localparam logic signed [LEVEL_W-1:0] LVL_HI = LEVEL_W'(MAX_LEVEL);
	localparam logic signed [LEVEL_W-1:0] LVL_LO = LEVEL_W'(-MAX_LEVEL);

	entry_t                mem_q [QUEUE_DEPTH];
	logic [QPTR_W-1:0]     wr_ptr_q;
	logic [QPTR_W-1:0]     rd_ptr_q;
	logic [QPTR_W:0]       count_q;
	logic                  push;
	logic                  do_pop;
	logic signed [LEVEL_W-1:0] req_lv;
	logic signed [LEVEL_W-1:0] sat_lv;
	entry_t                item;

	always_comb begin
		req_lv = signed'(s_axis_tdata[LEVEL_W-1:0]);
		if (req_lv > LVL_HI) begin
			sat_lv = LVL_HI;
		end else if (req_lv < LVL_LO) begin
			sat_lv = LVL_LO;
		end else begin
			sat_lv = req_lv;
		end
		item.func  = s_axis_tuser;
		item.level = sat_lv;
		item.ms    = s_axis_tdata[LEVEL_W +: MS_W];
	end

	assign s_axis_tready = (count_q != (QPTR_W+1)'(QUEUE_DEPTH));
	assign push          = s_axis_tvalid & s_axis_tready;
	assign head_valid    = (count_q != '0);
	assign do_pop        = pop & head_valid;
	assign head          = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			case ({push, do_pop})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

// ===== sv/mlsr_back.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mlsr_back: execution side of the level slew ramp
// Applies set-level requests, ramps on ticks and drives the result register.
// ----------------------------------------------------------------------------
module mlsr_back
	import mlsr_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_valid,
	input  logic [RATE_W-1:0]  cfg_data,
	input  logic               head_valid,
	input  entry_t             head,
	output logic               pop,
	output logic               out_valid,
	input  logic               out_ready,
	output logic [ANGLE_W-1:0] out_angle,
	output logic               out_last
);

	localparam logic [2:0] ST_IDLE = 3'd0;
	localparam logic [2:0] ST_MUL  = 3'd1;
	localparam logic [2:0] ST_DIV  = 3'd2;
	localparam logic [2:0] ST_FIN  = 3'd3;
	localparam logic [2:0] ST_REV  = 3'd4;

	localparam int DELTA_W   = RATE_W + MS_W;
	localparam int NUM_W     = DELTA_W + 2;
	localparam int MAG_W     = NUM_W - 1;
	localparam int RECIP_W   = 20;
	localparam int PROD_W    = MAG_W + RECIP_W;
	localparam int DIV_SHIFT = 29;
	localparam int QUO_W     = PROD_W - DIV_SHIFT;
	localparam int CALC_W    = QUO_W + 1;

	// ceil(2^29 / 1000): exact floor division for magnitudes below 2^19
	localparam logic [RECIP_W-1:0]      DIV_MULT = RECIP_W'(536871);
	localparam logic signed [NUM_W-1:0] SCALE    = NUM_W'(1000);

	localparam logic [LEVEL_W-1:0] LEVEL_NEG_ONE = {LEVEL_W{1'b1}};
	localparam logic [1:0]         REV_LAST      = 2'd3;

	logic [2:0]                 state_q, state_d;
	logic signed [LEVEL_W-1:0]  cur_q, cur_d;
	logic signed [LEVEL_W-1:0]  tgt_q, tgt_d;
	logic                       down_q, down_d;
	logic [RATE_W-1:0]          rate_q;
	logic [MS_W-1:0]            ms_q;
	logic [1:0]                 rev_idx_q, rev_idx_d;
	logic [DELTA_W-1:0]         delta_s1;
	logic [PROD_W-1:0]          prod_s2;
	logic                       neg_s2;
	logic                       ov_q;
	logic [ANGLE_W-1:0]         oa_q;
	logic                       ol_q;

	logic                       load_ok;
	logic                       ld;
	logic [ANGLE_W-1:0]         ld_angle;
	logic                       ld_last;
	logic signed [LEVEL_W-1:0]  lvl;
	logic signed [NUM_W-1:0]    delta_x;
	logic signed [NUM_W-1:0]    num;
	logic [MAG_W-1:0]           mag;
	logic [QUO_W-1:0]           quo;
	logic signed [CALC_W-1:0]   calc;
	logic signed [CALC_W-1:0]   tgt_x;
	logic signed [CALC_W-1:0]   nv_x;
	logic [ANGLE_W-1:0]         rev_angle;

	assign load_ok = !ov_q || out_ready;
	assign lvl     = signed'(head.level);

	// 1000*cur +- rate*ms, then its magnitude for the reciprocal multiply
	always_comb begin
		delta_x = signed'({2'b00, delta_s1});
		num     = NUM_W'(cur_q) * SCALE + (down_q ? -delta_x : delta_x);
		mag     = num[NUM_W-1] ? MAG_W'(-num) : MAG_W'(num);
	end

	// truncated quotient gets its sign back, then clamps to the target
	always_comb begin
		quo   = prod_s2[PROD_W-1:DIV_SHIFT];
		calc  = neg_s2 ? -signed'({1'b0, quo}) : signed'({1'b0, quo});
		tgt_x = CALC_W'(tgt_q);
		if (down_q) begin
			nv_x = (calc > tgt_x) ? calc : tgt_x;
		end else begin
			nv_x = (calc <= tgt_x) ? calc : tgt_x;
		end
	end

	// reversal: neutral, reverse kick, neutral, then level -1
	always_comb begin
		case (rev_idx_q)
			2'd0:    rev_angle = ANGLE_W'(180);
			2'd1:    rev_angle = ANGLE_W'(170);
			2'd2:    rev_angle = ANGLE_W'(180);
			default: rev_angle = angle_of(LEVEL_NEG_ONE);
		endcase
	end

	always_comb begin
		state_d   = state_q;
		cur_d     = cur_q;
		tgt_d     = tgt_q;
		down_d    = down_q;
		rev_idx_d = rev_idx_q;
		pop       = 1'b0;
		ld        = 1'b0;
		ld_angle  = angle_of(head.level);
		ld_last   = 1'b1;
		case (state_q)
			ST_IDLE: begin
				if (head_valid && load_ok) begin
					pop = 1'b1;
					if (head.func == FUNC_TICK) begin
						if (cur_q != tgt_q) begin
							state_d = ST_MUL;
						end
					end else if (lvl != tgt_q) begin
						tgt_d = lvl;
						if (!cur_q[LEVEL_W-1] && lvl[LEVEL_W-1]) begin
							cur_d     = signed'(LEVEL_NEG_ONE);
							down_d    = 1'b1;
							rev_idx_d = '0;
							state_d   = ST_REV;
						end else if (cur_q > 0 && !lvl[LEVEL_W-1]) begin
							if (lvl < cur_q) begin
								cur_d = lvl;
								ld    = 1'b1;
							end
						end else if (cur_q[LEVEL_W-1] && lvl <= 0) begin
							if (lvl > cur_q) begin
								cur_d = lvl;
								ld    = 1'b1;
							end
						end else begin
							down_d = !(lvl > cur_q);
						end
					end
				end
			end
			ST_MUL: begin
				state_d = ST_DIV;
			end
			ST_DIV: begin
				state_d = ST_FIN;
			end
			ST_FIN: begin
				if (load_ok) begin
					cur_d    = LEVEL_W'(nv_x);
					ld       = 1'b1;
					ld_angle = angle_of(LEVEL_W'(nv_x));
					state_d  = ST_IDLE;
				end
			end
			ST_REV: begin
				if (load_ok) begin
					ld        = 1'b1;
					ld_angle  = rev_angle;
					ld_last   = (rev_idx_q == REV_LAST);
					rev_idx_d = rev_idx_q + 1'b1;
					if (rev_idx_q == REV_LAST) begin
						state_d = ST_IDLE;
					end
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			ms_q <= head.ms;
		end
		delta_s1 <= rate_q * ms_q;
		prod_s2  <= mag * DIV_MULT;
		neg_s2   <= num[NUM_W-1];
		if (ld) begin
			oa_q <= ld_angle;
			ol_q <= ld_last;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			cur_q     <= '0;
			tgt_q     <= '0;
			down_q    <= 1'b0;
			rev_idx_q <= '0;
			rate_q    <= RATE_RESET;
			ov_q      <= 1'b0;
		end else begin
			state_q   <= state_d;
			cur_q     <= cur_d;
			tgt_q     <= tgt_d;
			down_q    <= down_d;
			rev_idx_q <= rev_idx_d;
			if (cfg_valid) begin
				rate_q <= cfg_data;
			end
			if (ld) begin
				ov_q <= 1'b1;
			end else if (out_ready) begin
				ov_q <= 1'b0;
			end
		end
	end

	assign out_valid = ov_q;
	assign out_angle = oa_q;
	assign out_last  = ol_q;

endmodule

// ===== sv/motor_level_slew_ramp.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// motor_level_slew_ramp: slew-rate limiter for a signed motor drive level
// Set-level beats retarget the drive, tick beats ramp it and emit angles.
// ----------------------------------------------------------------------------
//  channel   dir  handshake            contents
//  s_axis    in   tvalid/tready        tdata: new_level, elapsed_ms; tuser: func
//  m_axis    out  tvalid/tready        tdata: angle_half_deg; tlast: last
//  cfg       in   cfg_valid/cfg_ready  cfg_data: ramp_rate
//
// a four-entry queue lets intake take a beat every cycle while it has room.
// back end: a set-level item applies on take, a reversal takes it and emits four
// beats; a tick: take ms, rate*ms, scale and multiply by 1/1000, clamp and emit.
// each beat waits in the output register; a stalled m_axis holds the back end
// until the queue fills and drops s_axis_tready.
// reset is asynchronous and leaves level, target and ramp direction at zero.
// ----------------------------------------------------------------------------
module motor_level_slew_ramp
	import mlsr_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  s_axis_tvalid,
	output logic                  s_axis_tready,
	input  logic [IN_DATA_W-1:0]  s_axis_tdata,   // new_level[5:0], elapsed_ms[15:6]
	input  logic                  s_axis_tuser,   // func
	output logic                  m_axis_tvalid,
	input  logic                  m_axis_tready,
	output logic [OUT_DATA_W-1:0] m_axis_tdata,   // angle_half_deg[8:0], zero fill
	output logic                  m_axis_tlast,
	input  logic                  cfg_valid,
	output logic                  cfg_ready,
	input  logic [RATE_W-1:0]     cfg_data
);

	entry_t             head;
	logic               head_valid;
	logic               pop;
	logic [ANGLE_W-1:0] angle;

	mlsr_front u_front (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.pop           (pop),
		.head_valid    (head_valid),
		.head          (head)
	);

	mlsr_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_valid  (cfg_valid),
		.cfg_data   (cfg_data),
		.head_valid (head_valid),
		.head       (head),
		.pop        (pop),
		.out_valid  (m_axis_tvalid),
		.out_ready  (m_axis_tready),
		.out_angle  (angle),
		.out_last   (m_axis_tlast)
	);

	assign cfg_ready    = 1'b1;
	assign m_axis_tdata = OUT_DATA_W'(angle);

endmodule

// ===== bench/tb_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top: self-checking bench for the motor level slew ramp
// Drives set-level and tick beats with bursty timing and a stalling receiver.
// A scoreboard class tracks level, target, direction and ramp rate, predicts
// every angle beat and compares each output beat in order.
// ----------------------------------------------------------------------------
module tb_top;
	import mlsr_pkg::*;

	localparam int CLK_HALF     = 10;
	localparam int DRAIN_CYCLES = 40;
	localparam int IDLE_LIMIT   = 2000;
	localparam int HOLD_CYCLES  = 300;
	localparam int HOLD_AT      = 150;
	localparam int PHASE_ITEMS  = 44;
	localparam int NUM_PHASES   = 6;

	typedef struct packed {
		logic [ANGLE_W-1:0] angle;
		logic               last;
	} angle_beat_t;

	class angle_scoreboard;
		int          cur_level;
		int          tgt_level;
		bit          ramp_dn;
		int          rate;
		int          errors;
		angle_beat_t angle_q[$];

		function new();
			cur_level = 0;
			tgt_level = 0;
			ramp_dn   = 1'b0;
			rate      = int'(RATE_RESET);
			errors    = 0;
		endfunction

		function void set_rate(logic [RATE_W-1:0] r);
			rate = int'(r);
		endfunction

		function int pending();
			return angle_q.size();
		endfunction

		function void push_angle(int a, bit last);
			angle_beat_t b;
			b.angle = ANGLE_W'(a);
			b.last  = last;
			angle_q.push_back(b);
		endfunction

		// work out the angle beats caused by one accepted input beat
		function void note_item(logic func, logic [LEVEL_W-1:0] lvl, logic [MS_W-1:0] ms);
			int l;
			int delta;
			int num;
			int calc;
			if (func == FUNC_SET) begin
				l = $signed(lvl);
				if (l > MAX_LEVEL)
					l = MAX_LEVEL;
				if (l < -MAX_LEVEL)
					l = -MAX_LEVEL;
				if (l == tgt_level)
					return;
				tgt_level = l;
				// crossing into reverse: neutral, brake, neutral, then level -1
				if (cur_level >= 0 && l < 0) begin
					push_angle(180, 1'b0);
					push_angle(170, 1'b0);
					push_angle(180, 1'b0);
					cur_level = -1;
					push_angle(9 * cur_level + 180, 1'b1);
					ramp_dn = !(tgt_level > cur_level);
					return;
				end
				if (cur_level > 0 && l >= 0) begin
					if (l < cur_level) begin
						cur_level = l;
						push_angle(9 * cur_level + 180, 1'b1);
					end
					return;
				end
				if (cur_level < 0 && l <= 0) begin
					if (l > cur_level) begin
						cur_level = l;
						push_angle(9 * cur_level + 180, 1'b1);
					end
					return;
				end
				ramp_dn = !(tgt_level > cur_level);
			end else begin
				if (cur_level == tgt_level)
					return;
				delta = rate * int'(ms);
				num   = cur_level * 1000 + (ramp_dn ? -delta : delta);
				calc  = num / 1000;
				if (!ramp_dn)
					cur_level = (calc <= tgt_level) ? calc : tgt_level;
				else
					cur_level = (calc > tgt_level) ? calc : tgt_level;
				push_angle(9 * cur_level + 180, 1'b1);
			end
		endfunction

		function void check_beat(logic [OUT_DATA_W-1:0] data, logic last);
			angle_beat_t e;
			if (angle_q.size() == 0) begin
				$error("unexpected result beat: angle_half_deg %0d, last %0b",
					data[ANGLE_W-1:0], last);
				errors++;
				return;
			end
			e = angle_q.pop_front();
			if (data[ANGLE_W-1:0] !== e.angle) begin
				$error("angle_half_deg: expected %0d, actual %0d", e.angle, data[ANGLE_W-1:0]);
				errors++;
			end
			if (last !== e.last) begin
				$error("last: expected %0b, actual %0b", e.last, last);
				errors++;
			end
			if (data[OUT_DATA_W-1:ANGLE_W] !== '0) begin
				$error("tdata fill: expected 0, actual %0h", data[OUT_DATA_W-1:ANGLE_W]);
				errors++;
			end
		endfunction
	endclass

	logic                  clk;
	logic                  arst_n        = 1'b0;
	logic                  s_axis_tvalid = 1'b0;
	logic                  s_axis_tready;
	logic [IN_DATA_W-1:0]  s_axis_tdata  = '0;   // new_level[5:0], elapsed_ms[15:6]
	logic                  s_axis_tuser  = 1'b0; // func
	logic                  m_axis_tvalid;
	logic                  m_axis_tready = 1'b0;
	logic [OUT_DATA_W-1:0] m_axis_tdata;         // angle_half_deg[8:0], zero fill
	logic                  m_axis_tlast;
	logic                  cfg_valid     = 1'b0;
	logic                  cfg_ready;
	logic [RATE_W-1:0]     cfg_data      = '0;

	angle_scoreboard sb = new();

	int sent       = 0;
	int burst_left = 0;
	bit steady     = 1'b0;

	motor_level_slew_ramp u_top (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tlast  (m_axis_tlast),
		.cfg_valid     (cfg_valid),
		.cfg_ready     (cfg_ready),
		.cfg_data      (cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #CLK_HALF clk = ~clk;
	end

	// beats are taken at the rising edge, before the block updates
	always @(posedge clk) begin
		if (s_axis_tvalid && s_axis_tready)
			sb.note_item(s_axis_tuser, s_axis_tdata[LEVEL_W-1:0],
				s_axis_tdata[LEVEL_W+MS_W-1:LEVEL_W]);
		if (m_axis_tvalid && m_axis_tready)
			sb.check_beat(m_axis_tdata, m_axis_tlast);
	end

	initial begin : watchdog
		int idle_cnt;
		idle_cnt = 0;
		while (idle_cnt < IDLE_LIMIT) begin
			@(posedge clk);
			if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
				(cfg_valid && cfg_ready))
				idle_cnt = 0;
			else
				idle_cnt++;
		end
		$display("CHECKS FAILED");
		$finish;
	end

	// receiver: changing stall patterns plus one long hold-off
	initial begin : receiver
		int mode;
		int left;
		int hold;
		int cyc;
		bit held;
		bit rdy;
		mode = 0;
		left = 0;
		hold = 0;
		cyc  = 0;
		held = 1'b0;
		forever begin
			@(negedge clk);
			cyc++;
			if (!held && sent >= HOLD_AT) begin
				held = 1'b1;
				hold = HOLD_CYCLES;
			end
			if (hold > 0) begin
				hold--;
				m_axis_tready <= 1'b0;
			end else begin
				if (left == 0) begin
					mode = $urandom_range(0, 3);
					left = $urandom_range(20, 80);
				end
				left--;
				case (mode)
					0: rdy = 1'b1;
					1: rdy = 1'($urandom_range(0, 1));
					2: rdy = ($urandom_range(0, 9) != 0);
					default: rdy = ((cyc % 5) != 0);
				endcase
				m_axis_tready <= rdy;
			end
		end
	end

	task automatic send_item(logic f, logic [LEVEL_W-1:0] lv, logic [MS_W-1:0] ms);
		int gap;
		gap = 0;
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 16);
			gap = steady ? 0 : $urandom_range(1, 10);
		end
		burst_left--;
		if (gap > 0) begin
			@(negedge clk);
			s_axis_tvalid <= 1'b0;
			repeat (gap - 1) @(negedge clk);
		end
		@(negedge clk);
		s_axis_tvalid <= 1'b1;
		s_axis_tdata  <= {ms, lv};
		s_axis_tuser  <= f;
		do @(posedge clk); while (!s_axis_tready);
		sent++;
	endtask

	task automatic rand_item();
		logic                f;
		logic [LEVEL_W-1:0]  lv;
		logic [MS_W-1:0]     ms;
		int                  k;
		k  = $urandom_range(0, 99);
		lv = LEVEL_W'($urandom);
		ms = MS_W'($urandom);
		if (k < 42) begin
			f = FUNC_SET;
			if (k < 36)
				lv = LEVEL_W'(int'($urandom_range(0, 40)) - 20);
		end else begin
			f = FUNC_TICK;
			if (k < 88)
				ms = MS_W'($urandom_range(0, 300));
		end
		send_item(f, lv, ms);
	endtask

	// let every expected beat arrive, then let the queue run dry
	task automatic drain();
		@(negedge clk);
		s_axis_tvalid <= 1'b0;
		while (sb.pending() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic write_rate(logic [RATE_W-1:0] r);
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_data  <= r;
		do @(posedge clk); while (!cfg_ready);
		sb.set_rate(r);
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	initial begin : stimulus
		logic [RATE_W-1:0] phase_rate [NUM_PHASES];
		phase_rate[0] = 8'd0;
		phase_rate[1] = 8'd255;
		phase_rate[2] = 8'd1;
		phase_rate[3] = RATE_W'($urandom_range(2, 254));
		phase_rate[4] = RATE_W'($urandom);
		phase_rate[5] = RATE_RESET;

		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// directed part at the reset ramp rate
		send_item(FUNC_TICK, 6'd0, 10'd1023);        // at target after reset
		send_item(FUNC_SET, 6'd0, 10'd0);            // same target
		send_item(FUNC_SET, 6'h1F, 10'd0);           // saturates to +20, ramp up
		send_item(FUNC_TICK, 6'd0, 10'd100);
		send_item(FUNC_TICK, 6'd0, 10'd1023);        // clamps at target
		send_item(FUNC_TICK, 6'd0, 10'd0);
		send_item(FUNC_SET, 6'd8, 10'd0);            // cut on the positive side
		send_item(FUNC_SET, 6'd15, 10'd0);           // raise, no beat
		send_item(FUNC_TICK, 6'd0, 10'd50);
		send_item(FUNC_TICK, 6'd0, 10'd0);           // zero step still emits
		send_item(FUNC_SET, 6'h20, 10'd0);           // saturates to -20, reversal
		send_item(FUNC_TICK, 6'd0, 10'd999);
		send_item(FUNC_SET, 6'(-5), 10'd0);          // cut on the negative side
		send_item(FUNC_SET, 6'(-12), 10'd0);         // deeper, no beat
		send_item(FUNC_TICK, 6'd0, 10'd30);          // truncates toward zero
		send_item(FUNC_SET, 6'd3, 10'd0);            // back across, ramp up
		send_item(FUNC_TICK, 6'd0, 10'd1023);
		send_item(FUNC_SET, 6'd0, 10'd0);
		send_item(FUNC_SET, 6'(-1), 10'd0);          // reversal onto -1 itself
		send_item(FUNC_TICK, 6'd0, 10'd5);
		send_item(FUNC_SET, 6'd20, 10'h3FF);
		send_item(FUNC_TICK, 6'h2A, 10'd1);          // -0.94 truncates to 0
		send_item(FUNC_TICK, 6'h3F, 10'd1023);
		drain();

		for (int ph = 0; ph < NUM_PHASES; ph++) begin
			write_rate(phase_rate[ph]);
			steady = ($urandom_range(0, 3) == 0);
			repeat (PHASE_ITEMS + $urandom_range(0, 8)) rand_item();
			drain();
		end

		if (sb.errors == 0 && sb.pending() == 0) begin
			$display("ALL CHECKS PASSED");
		end else begin
			if (sb.pending() != 0)
				$error("%0d expected beats never arrived", sb.pending());
			$display("CHECKS FAILED");
		end
		$finish;
	end

endmodule
